[sv/scfp_pkg.sv]
// Package with shared types, constants and the CRC-8 step function of the frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned IDX_W     = $clog2(FRAME_LEN);
    localparam int unsigned CNT_W     = IDX_W + 1;

    localparam logic [7:0] SYNC_RESET = 8'd170;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_TOP    = 8'h80;

    localparam logic [1:0] STATUS_NONE  = 2'd0;
    localparam logic [1:0] STATUS_FRAME = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_SHIFT
    } state_t;

    typedef struct packed {
        logic take;
        logic emit_none;
        logic emit_frame;
        logic emit_error;
        logic crc_init;
        logic crc_step;
        logic clear_cnt;
        logic shift;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic cnt_zero;
        logic frame_done;
        logic crc_last;
        logic crc_ok;
        logic head_sync;
    } stat_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'd0) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[sv/sync_crc8_frame_parser.sv]
// Top level of the sync byte frame parser with CRC-8 check.
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid / in_stall  rx_byte
//  output    out        out_valid/ out_stall status, sequence_res, throttle, rudder,
//                                            yaw, pitch, flag_bits
//  config    in         cfg_valid/ cfg_ready sync_value
//
// A byte that does not complete a frame yields a result of status none. The eighth byte
// of a frame is stored, then the CRC unit folds buffered bytes 0 to 6, one byte per
// cycle, and the result is reported when the output is free. A failed frame then
// shifts the buffer down to the next sync byte or until it is empty. Reset empties the
// buffer and restores the sync value; the buffer contents need no clearing. A stalled
// result holds the input off only when a new result would have to overwrite it.
`timescale 1ns / 1ps

module sync_crc8_frame_parser
    import scfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [7:0]        sequence_res,
    output logic signed [7:0] throttle,
    output logic signed [7:0] rudder,
    output logic signed [7:0] yaw,
    output logic signed [7:0] pitch,
    output logic [7:0]        flag_bits,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        sync_value
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    scfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    scfp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .rx_byte      (rx_byte),
        .cfg_valid    (cfg_valid),
        .sync_value   (sync_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .sequence_res (sequence_res),
        .throttle     (throttle),
        .rudder       (rudder),
        .yaw          (yaw),
        .pitch        (pitch),
        .flag_bits    (flag_bits)
    );

endmodule

[sv/scfp_dp.sv]
// Datapath of the frame parser: frame buffer, fill count, CRC unit and result register.
`timescale 1ns / 1ps

module scfp_dp
    import scfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_valid,
    input  logic [7:0]        sync_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [7:0]        sequence_res,
    output logic signed [7:0] throttle,
    output logic signed [7:0] rudder,
    output logic signed [7:0] yaw,
    output logic signed [7:0] pitch,
    output logic [7:0]        flag_bits
);

    logic [7:0]       buf_reg  [FRAME_LEN];
    logic [7:0]       buf_next [FRAME_LEN];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       sync_reg, sync_next;
    logic [7:0]       crc_reg, crc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       field_reg  [1:FRAME_LEN-2];
    logic [7:0]       field_next [1:FRAME_LEN-2];
    logic             emit;

    assign emit = cmd.emit_none | cmd.emit_frame | cmd.emit_error;

    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.frame_done = (cnt_reg == CNT_W'(FRAME_LEN - 1));
    assign stat.crc_last   = (idx_reg == IDX_W'(FRAME_LEN - 2));
    assign stat.head_sync  = (buf_reg[0] == sync_reg);
    assign stat.crc_ok     = (buf_reg[0] == sync_reg) && (buf_reg[FRAME_LEN-1] == crc_reg);

    always_comb
    begin
        sync_next = cfg_valid ? sync_value : sync_reg;
    end

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (cmd.take)
        begin
            if (cnt_reg == '0)
            begin
                if (rx_byte == sync_reg)
                begin
                    buf_next[0] = rx_byte;
                    cnt_next    = CNT_W'(1);
                end
            end
            else
            begin
                buf_next[cnt_reg[IDX_W-1:0]] = rx_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
        else if (cmd.shift)
        begin
            for (int j = 0; j < FRAME_LEN - 1; j++)
            begin
                buf_next[j] = buf_reg[j+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else if (cmd.clear_cnt)
        begin
            cnt_next = '0;
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        idx_next = idx_reg;
        if (cmd.crc_init)
        begin
            crc_next = '0;
            idx_next = '0;
        end
        else if (cmd.crc_step)
        begin
            crc_next = crc8_byte(crc_reg, buf_reg[idx_reg]);
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        field_next     = field_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            priority if (cmd.emit_frame)
            begin
                status_next = STATUS_FRAME;
            end
            else if (cmd.emit_error)
            begin
                status_next = STATUS_ERROR;
            end
            else
            begin
                status_next = STATUS_NONE;
            end
            for (int j = 1; j <= FRAME_LEN - 2; j++)
            begin
                field_next[j] = cmd.emit_frame ? buf_reg[j] : 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            sync_reg      <= SYNC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            sync_reg      <= sync_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        crc_reg    <= crc_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        field_reg  <= field_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign sequence_res = field_reg[1];
    assign throttle     = field_reg[2];
    assign rudder       = field_reg[3];
    assign yaw          = field_reg[4];
    assign pitch        = field_reg[5];
    assign flag_bits    = field_reg[6];

endmodule

[sv/scfp_ctrl.sv]
// Controller state machine of the frame parser.
`timescale 1ns / 1ps

module scfp_ctrl
    import scfp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign accept = (state_reg == S_IDLE) && in_valid && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !stat.cnt_zero && stat.frame_done)
                begin
                    state_next = S_CRC;
                end
            end
            S_CRC:
            begin
                if (stat.crc_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.crc_ok ? S_IDLE : S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.cnt_zero || stat.head_sync)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = !stat.out_free;
                if (accept)
                begin
                    cmd.take = 1'b1;
                    if (!stat.cnt_zero && stat.frame_done)
                    begin
                        cmd.crc_init = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_none = 1'b1;
                    end
                end
            end
            S_CRC:
            begin
                cmd.crc_step = 1'b1;
            end
            S_CHECK:
            begin
                if (stat.out_free)
                begin
                    if (stat.crc_ok)
                    begin
                        cmd.emit_frame = 1'b1;
                        cmd.clear_cnt  = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_error = 1'b1;
                        cmd.shift      = 1'b1;
                    end
                end
            end
            S_SHIFT:
            begin
                if (!stat.cnt_zero && !stat.head_sync)
                begin
                    cmd.shift = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[tb/sv/sync_crc8_frame_parser_tb.sv]
// Self-checking testbench for the sync byte frame parser with CRC-8 check.
`timescale 1ns / 1ps

module sync_crc8_frame_parser_tb
    import scfp_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 560;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        sequence_res;
        logic signed [7:0] throttle;
        logic signed [7:0] rudder;
        logic signed [7:0] yaw;
        logic signed [7:0] pitch;
        logic [7:0]        flag_bits;
    } frame_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [7:0]        sequence_res;
    logic signed [7:0] throttle;
    logic signed [7:0] rudder;
    logic signed [7:0] yaw;
    logic signed [7:0] pitch;
    logic [7:0]        flag_bits;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [7:0]        sync_value;

    logic [7:0]    model_sync;
    logic [7:0]    model_frame [0:7];
    int unsigned   model_fill;
    frame_result_t pending_results [$];
    int            errors = 0;
    int            cycles = 0;
    int            random_items;
    bit            idle_enable;
    int            hold_left;

    sync_crc8_frame_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .sequence_res (sequence_res),
        .throttle     (throttle),
        .rudder       (rudder),
        .yaw          (yaw),
        .pitch        (pitch),
        .flag_bits    (flag_bits),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .sync_value   (sync_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // CRC-8 over frame bytes 0 to 6, byte 0 in the top bits.
    function automatic logic [7:0] crc8_of_head(input logic [55:0] head);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 6; i >= 0; i--)
        begin
            c = c ^ head[i*8 +: 8];
            for (int k = 0; k < 8; k++)
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic frame_result_t parse_byte(input logic [7:0] b);
        frame_result_t r;
        logic [55:0]   head;
        r = '0;
        if (model_fill == 0)
        begin
            if (b == model_sync)
            begin
                model_frame[0] = b;
                model_fill = 1;
            end
            return r;
        end
        model_frame[model_fill] = b;
        model_fill++;
        if (model_fill < 8)
            return r;
        head = {model_frame[0], model_frame[1], model_frame[2], model_frame[3],
                model_frame[4], model_frame[5], model_frame[6]};
        model_fill = 0;
        if (model_frame[0] == model_sync && model_frame[7] == crc8_of_head(head))
        begin
            r.status       = STATUS_FRAME;
            r.sequence_res = model_frame[1];
            r.throttle     = model_frame[2];
            r.rudder       = model_frame[3];
            r.yaw          = model_frame[4];
            r.pitch        = model_frame[5];
            r.flag_bits    = model_frame[6];
        end
        else
        begin
            r.status = STATUS_ERROR;
            for (int pos = 1; pos < 8 && model_fill == 0; pos++)
            begin
                if (model_frame[pos] == model_sync)
                begin
                    for (int j = 0; j < 8 - pos; j++)
                        model_frame[j] = model_frame[pos + j];
                    model_fill = 8 - pos;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] some_byte();
        logic [7:0] v;
        v = 8'($urandom_range(255));
        if ($urandom_range(9) == 0)
            v = model_sync;
        return v;
    endfunction

    function automatic logic [47:0] random_body();
        logic [47:0] body;
        for (int i = 0; i < 6; i++)
            body[i*8 +: 8] = some_byte();
        return body;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= 40)
            $display("cycle %0d: %s mismatch, got 0x%02h, expected 0x%02h",
                     cycles, field, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        while (idle_enable && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(parse_byte(b));
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [47:0] body, input logic [7:0] crc_flip);
        logic [55:0] head;
        head = {model_sync, body};
        for (int i = 6; i >= 0; i--)
            send_byte(head[i*8 +: 8]);
        send_byte(crc8_of_head(head) ^ crc_flip);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        drain();
        cfg_valid  <= 1'b1;
        sync_value <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        model_sync = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame({8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'hFF}, 8'h00);
        // Bad CRC with a sync byte stored as data at position 4, so resync shifts.
        send_frame({8'hFF, 8'h7F, 8'h80, SYNC_RESET, 8'h01, 8'h00}, 8'h5A);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
        drain();
    endtask

    task automatic test_sync_change();
        logic [55:0] head;
        head = {SYNC_RESET, 8'h11, 8'h22, 8'h33, 8'h55, 8'h44, 8'h66};
        write_sync(SYNC_RESET);
        send_byte(SYNC_RESET);
        send_byte(8'h11);
        send_byte(8'h22);
        // The frame started under the old value must fail and resync on the new one.
        write_sync(8'h55);
        send_byte(8'h33);
        send_byte(8'h55);
        send_byte(8'h44);
        send_byte(8'h66);
        send_byte(crc8_of_head(head));
        repeat (4) send_byte(some_byte());
        write_sync(SYNC_RESET);
    endtask

    task automatic test_sync_extremes();
        write_sync(8'h00);
        repeat (3) send_frame(random_body(), 8'h00);
        send_frame(random_body(), 8'h01);
        repeat (3) send_byte(some_byte());
        write_sync(8'hFF);
        repeat (3) send_frame(random_body(), 8'h00);
        send_frame(random_body(), 8'h80);
        repeat (3) send_byte(some_byte());
        write_sync(SYNC_RESET);
    endtask

    task automatic test_backpressure();
        hold_left = 150;
        repeat (5) send_frame(random_body(), 8'h00);
        drain();
    endtask

    task automatic test_random();
        int         r;
        int         n;
        logic [7:0] flip;
        logic [7:0] v;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            idle_enable = !(random_items >= 200 && random_items < 320);
            r = $urandom_range(99);
            if (r < 3)
            begin
                v = 8'($urandom_range(255));
                write_sync(v);
            end
            else if (r < 70)
            begin
                flip = 8'h00;
                if ($urandom_range(6) == 0)
                    flip = 8'($urandom_range(255, 1));
                send_frame(random_body(), flip);
                random_items += 8;
            end
            else if (r < 85)
            begin
                n = $urandom_range(6, 1);
                repeat (n) send_byte(8'($urandom_range(255)));
                random_items += n;
            end
            else
            begin
                n = $urandom_range(7, 1);
                send_byte(model_sync);
                repeat (n - 1) send_byte(some_byte());
                random_items += n;
            end
        end
        idle_enable = 1'b1;
        drain();
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= idle_enable && ($urandom_range(99) < 37);
            end
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, status", {6'd0, status}, 8'h00);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", {6'd0, status}, {6'd0, want.status});
                if (sequence_res !== want.sequence_res)
                    report_mismatch("sequence_res", sequence_res, want.sequence_res);
                if (throttle !== want.throttle)
                    report_mismatch("throttle", throttle, want.throttle);
                if (rudder !== want.rudder)
                    report_mismatch("rudder", rudder, want.rudder);
                if (yaw !== want.yaw)
                    report_mismatch("yaw", yaw, want.yaw);
                if (pitch !== want.pitch)
                    report_mismatch("pitch", pitch, want.pitch);
                if (flag_bits !== want.flag_bits)
                    report_mismatch("flag_bits", flag_bits, want.flag_bits);
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = 8'h00;
        cfg_valid   = 1'b0;
        sync_value  = SYNC_RESET;
        idle_enable = 1'b1;
        hold_left   = 0;
        model_sync  = SYNC_RESET;
        model_fill  = 0;
        for (int i = 0; i < 8; i++)
            model_frame[i] = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_sync_change();
        test_sync_extremes();
        test_backpressure();
        test_random();
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
